// File: design/pcrq_pkg.sv
// ============================================================================
// pcrq_pkg: shared types and codes for the per-CPU run queue block
// Holds the request and result structs, function codes and status codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pcrq_pkg;

    localparam int FIELD_ID_BITS = 16;

    typedef enum logic [1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_PICK    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    localparam logic [0:0] CFG_ACTIVE_CPUS = 1'b0;
    localparam logic [0:0] CFG_SPREAD_MODE = 1'b1;

    typedef struct packed {
        logic [1:0]               func;
        logic [FIELD_ID_BITS-1:0] thread_id;
        logic [2:0]               cpu;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [FIELD_ID_BITS-1:0] picked_thread;
        logic [2:0]               queue_used;
        logic                     stolen;
    } rsp_t;

endpackage

`default_nettype wire

// File: design/per_cpu_run_queue_stealer.sv
// ============================================================================
// per_cpu_run_queue_stealer: per-CPU FIFO run queues with work stealing
// One ring buffer per CPU in a shared slot memory; enqueue, remove by id
// with gap closing, and pick with stealing from the lowest active queue.
// ============================================================================
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------
//  req      | in        | req_valid/stall  | func, thread_id, cpu
//  rsp      | out       | rsp_valid/stall  | status, picked_thread, ...
//  cfg      | in        | cfg_we           | cfg_index, cfg_data
//
// One request is worked on at a time. A remove reads the active queues slot
// by slot through the slot memory, whose read data is registered: it compares
// each occupied slot searched, steps over to the next queue when one runs
// out, and after a hit shifts the later slots down one place. Reset clears
// fill counts, heads and the placement pointer at once; no clearing pass is
// needed. The result sits in an output register; while it is stalled, the
// next request is taken only after the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_run_queue_stealer #(
    parameter int CPU_COUNT   = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire pcrq_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output pcrq_pkg::rsp_t       rsp,
    input  wire logic            cfg_we,
    input  wire logic [0:0]      cfg_index,
    input  wire logic [3:0]      cfg_data
);
    import pcrq_pkg::*;

    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = CW + PW;
    localparam int NW = $clog2(CPU_COUNT + 1);
    localparam int IW = (ID_BITS < FIELD_ID_BITS) ? ID_BITS : FIELD_ID_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DISP   = 7'b0000010,
        S_SREAD  = 7'b0000100,
        S_SCMP   = 7'b0001000,
        S_SHRD   = 7'b0010000,
        S_SHWR   = 7'b0100000,
        S_PICK   = 7'b1000000
    } state_t;

    // Slot memory: one read port and one write port, read data registered.
    logic [IW-1:0] mem [CPU_COUNT*QUEUE_DEPTH];
    logic [IW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [IW-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    logic [FW-1:0] fill_reg [CPU_COUNT];
    logic [PW-1:0] head_reg [CPU_COUNT];
    logic [CW-1:0] ptr_reg;
    logic [NW-1:0] active_reg;
    logic          spread_reg;
    state_t        state_reg;
    req_t          req_reg;
    rsp_t          rsp_reg;
    logic          rsp_valid_reg;
    logic [CW-1:0] q_reg;
    logic [FW-1:0] p_reg;
    logic          stolen_reg;

    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] q,
                                              input logic [PW-1:0] head,
                                              input logic [FW-1:0] pos);
        logic [PW:0] s;
        s = {1'b0, head} + (PW+1)'(pos);
        if (QUEUE_DEPTH != (1 << PW) && s >= (PW+1)'(QUEUE_DEPTH))
        begin
            s = s - (PW+1)'(QUEUE_DEPTH);
        end
        return AW'(q * QUEUE_DEPTH) + AW'(s[PW-1:0]);
    endfunction

    // Pick choice: own queue first, else the lowest other non-empty active.
    logic          pick_found;
    logic [CW-1:0] pick_q;
    logic          pick_steal;

    always_comb
    begin
        pick_found = 1'b0;
        pick_q     = '0;
        pick_steal = 1'b0;
        if ({1'b0, req_reg.cpu} < 4'(active_reg) && 32'(req_reg.cpu) < CPU_COUNT
            && fill_reg[CW'(req_reg.cpu)] != '0)
        begin
            pick_found = 1'b1;
            pick_q     = CW'(req_reg.cpu);
        end
        else
        begin
            for (int i = CPU_COUNT - 1; i >= 0; i--)
            begin
                if (i < int'(active_reg) && i != int'(req_reg.cpu) && fill_reg[i] != '0)
                begin
                    pick_found = 1'b1;
                    pick_q     = CW'(i);
                    pick_steal = 1'b1;
                end
            end
        end
    end

    logic [CW-1:0] enq_q;
    assign enq_q = (spread_reg && NW'(ptr_reg) < active_reg) ? ptr_reg : '0;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(q_reg, head_reg[q_reg], p_reg);
        mem_wdata = rd_data_reg;
        mem_raddr = addr_of(q_reg, head_reg[q_reg], p_reg);
        case (state_reg)
            S_DISP:
            begin
                if (req_reg.func == FUNC_ENQUEUE && fill_reg[enq_q] < FW'(QUEUE_DEPTH))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(enq_q, head_reg[enq_q], fill_reg[enq_q]);
                    mem_wdata = req_reg.thread_id[IW-1:0];
                end
                mem_raddr = addr_of(pick_q, head_reg[pick_q], '0);
            end
            S_SHRD:
            begin
                mem_raddr = addr_of(q_reg, head_reg[q_reg], p_reg + FW'(1));
            end
            S_SHWR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            ptr_reg       <= '0;
            active_reg    <= NW'(1);
            spread_reg    <= 1'b0;
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            q_reg         <= '0;
            p_reg         <= '0;
            stolen_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACTIVE_CPUS)
                begin
                    if (cfg_data == 4'd0)
                        active_reg <= NW'(1);
                    else if (32'(cfg_data) > CPU_COUNT)
                        active_reg <= NW'(CPU_COUNT);
                    else
                        active_reg <= NW'(cfg_data);
                end
                else
                begin
                    spread_reg <= cfg_data[0];
                end
            end
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && !req_stall && req.func != FUNC_NONE)
                    begin
                        req_reg   <= req;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    case (req_reg.func)
                        FUNC_ENQUEUE:
                        begin
                            if (fill_reg[enq_q] >= FW'(QUEUE_DEPTH))
                            begin
                                rsp_reg <= '{status: ST_FULL, picked_thread: '0,
                                             queue_used: 3'(enq_q), stolen: 1'b0};
                            end
                            else
                            begin
                                rsp_reg <= '{status: ST_OK, picked_thread: '0,
                                             queue_used: 3'(enq_q), stolen: 1'b0};
                                fill_reg[enq_q] <= fill_reg[enq_q] + FW'(1);
                                if (spread_reg)
                                    ptr_reg <= (NW'(enq_q) + NW'(1) >= active_reg)
                                               ? '0 : enq_q + CW'(1);
                            end
                            rsp_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        FUNC_REMOVE:
                        begin
                            q_reg     <= '0;
                            p_reg     <= '0;
                            state_reg <= S_SREAD;
                        end
                        default:
                        begin
                            if (pick_found)
                            begin
                                q_reg      <= pick_q;
                                stolen_reg <= pick_steal;
                                state_reg  <= S_PICK;
                            end
                            else
                            begin
                                rsp_reg <= '{status: ST_EMPTY, picked_thread: '0,
                                             queue_used: '0, stolen: 1'b0};
                                rsp_valid_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_PICK:
                begin
                    rsp_reg <= '{status: ST_OK,
                                 picked_thread: FIELD_ID_BITS'(rd_data_reg),
                                 queue_used: 3'(q_reg), stolen: stolen_reg};
                    head_reg[q_reg] <= (32'(head_reg[q_reg]) + 1 >= QUEUE_DEPTH)
                                       ? '0 : head_reg[q_reg] + PW'(1);
                    fill_reg[q_reg] <= fill_reg[q_reg] - FW'(1);
                    rsp_valid_reg   <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                S_SREAD:
                begin
                    // Walk to the next occupied slot, or finish on a miss.
                    if (p_reg < fill_reg[q_reg])
                    begin
                        state_reg <= S_SCMP;
                    end
                    else if (NW'(q_reg) + NW'(1) < active_reg)
                    begin
                        q_reg <= q_reg + CW'(1);
                        p_reg <= '0;
                    end
                    else
                    begin
                        rsp_reg <= '{status: ST_NOT_FOUND, picked_thread: '0,
                                     queue_used: '0, stolen: 1'b0};
                        rsp_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_SCMP:
                begin
                    if (rd_data_reg == req_reg.thread_id[IW-1:0])
                    begin
                        state_reg <= S_SHRD;
                    end
                    else
                    begin
                        p_reg     <= p_reg + FW'(1);
                        state_reg <= S_SREAD;
                    end
                end
                S_SHRD:
                begin
                    // Close the gap one entry at a time, then drop the tail.
                    if (p_reg + FW'(1) < fill_reg[q_reg])
                    begin
                        state_reg <= S_SHWR;
                    end
                    else
                    begin
                        fill_reg[q_reg]    <= fill_reg[q_reg] - FW'(1);
                        rsp_reg <= '{status: ST_OK, picked_thread: '0,
                                     queue_used: 3'(q_reg), stolen: 1'b0};
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                S_SHWR:
                begin
                    p_reg     <= p_reg + FW'(1);
                    state_reg <= S_SHRD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
